FILE: rtl/core/vibration_envelope_tracker_defines.svh
// Assertion macros for the vibration envelope tracker.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef VIBRATION_ENVELOPE_TRACKER_DEFINES_SVH
`define VIBRATION_ENVELOPE_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VET_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vet_pkg.sv
// Shared types and constants of the vibration envelope tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package vet_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int NUM_AXES    = 3;

    localparam int COEF_W   = 16;
    localparam int HP_W     = 32;                 // Q23.8 filter / envelope state
    localparam int SUM_W    = HP_W + 1;           // hp + (diff << 8)
    localparam int PROD_W   = SUM_W + COEF_W + 1; // sum * a
    localparam int SQ_W     = 2 * HP_W;           // Q48.16 squares
    localparam int ROOT_W   = SQ_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int DELTA_W  = ROOT_W + 2;         // mag - env
    localparam int EPROD_W  = DELTA_W + COEF_W + 1;
    localparam int ESUM_W   = EPROD_W - COEF_W + 1;
    localparam int LEVEL_W  = 24;
    localparam int FRAC_W   = 8;

    localparam int IN_TDATA_W  = ((NUM_AXES * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LEVEL_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HP_COEFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(2);

    localparam logic [COEF_W-1:0] HP_COEFF_RST = COEF_W'(62259);
    localparam logic [COEF_W-1:0] ENV_GAIN_RST = COEF_W'(13107);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // previous-sample values after reset, x / y / z
    localparam t_sample LAST_RST [NUM_AXES] = '{
        t_sample'(-19), t_sample'(-51), t_sample'(1032)
    };

    typedef struct packed {
        logic            valid;
        logic [SQ_W-1:0] sq;
    } t_lane_out;

endpackage

`default_nettype wire

FILE: rtl/core/vibration_envelope_tracker.sv
// Vibration envelope tracker top level: config registers, three filter lanes,
// square-sum merge, square root, envelope and output register.
// Depends on vet_pkg, vet_lane, vet_isqrt, vet_env and the defines header.
`default_nettype none
`include "vibration_envelope_tracker_defines.svh"

// One three-axis sample word goes in, one envelope level word comes out, unless
// tracker_enable is 0, in which case the word is taken and dropped with no state
// change. Words are processed one at a time: a new word is not taken until the
// previous one has passed the filter lanes, the 32-step square root and the
// envelope and has been loaded into the output register. The result waits in the
// output register, so the next word can be accepted while it is still not
// taken; if a second result finishes before the first is taken, the input stays
// stalled until it is. Config writes are always accepted and must only be
// issued while the block is idle.
module vibration_envelope_tracker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [vet_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [vet_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [11:0] sample_x, [23:12] sample_y, [35:24] sample_z, rest zero
    input  wire logic [vet_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // level stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [23:0] vibration_level
    output logic [vet_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata
);
    import vet_pkg::*;

    logic [COEF_W-1:0]     r_hp_coeff;
    logic [COEF_W-1:0]     r_env_gain;
    logic                  r_enable;
    logic                  r_busy;
    logic                  r_pend;
    logic                  r_out_valid;
    logic [LEVEL_W-1:0]    r_out_data;

    logic                  in_accept;
    logic                  start;
    logic                  load;
    t_lane_out             lane_out [NUM_AXES];
    logic                  lane_any;
    logic                  lane_all;
    logic [SQ_W-1:0]       sum_sq;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     root;
    logic                  env_done;
    logic [LEVEL_W-1:0]    level;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_busy;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign start           = in_accept && r_enable;
    assign load            = r_pend && (!r_out_valid || i_m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_lane
            vet_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_start    (start),
                .i_sample   (i_s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
                .i_last_rst (LAST_RST[g]),
                .i_coeff    (r_hp_coeff),
                .o_out      (lane_out[g])
            );
        end
    endgenerate

    assign lane_any = lane_out[0].valid || lane_out[1].valid || lane_out[2].valid;
    assign lane_all = lane_out[0].valid && lane_out[1].valid && lane_out[2].valid;

    // merge: squares sum exactly, no carry out (each is at most 2^62)
    assign sum_sq = lane_out[0].sq + lane_out[1].sq + lane_out[2].sq;

    vet_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_out[0].valid),
        .i_radicand (sum_sq),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    vet_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_done),
        .i_mag   (root),
        .i_gain  (r_env_gain),
        .o_done  (env_done),
        .o_level (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_coeff  <= HP_COEFF_RST;
            r_env_gain  <= ENV_GAIN_RST;
            r_enable    <= 1'b1;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                priority if (i_cfg_index == CFG_HP_COEFF) begin
                    r_hp_coeff <= i_cfg_data;
                end else if (i_cfg_index == CFG_ENV_GAIN) begin
                    r_env_gain <= i_cfg_data;
                end else if (i_cfg_index == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else begin
                    r_enable <= r_enable;
                end
            end

            if (start) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end

            if (env_done) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end

            if (load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= level;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    `VET_ASSERT_IMPL(a_lanes_aligned, lane_any, lane_all, "filter lanes out of step")
    `VET_ASSERT_IMPL(a_root_in_flight, sqrt_done, r_busy, "root done with no word in flight")
    `VET_ASSERT_IMPL(a_env_no_overrun, env_done, r_busy && !r_pend, "pending result overrun")
    `VET_ASSERT_NEXT(a_env_to_pend, env_done, r_pend, "envelope result not held for output")

endmodule

`default_nettype wire

FILE: rtl/core/vet_lane.sv
// One axis lane: high-pass filter in Q23.8 with saturation, then the square.
// Depends on vet_pkg.
`default_nettype none

module vet_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire vet_pkg::t_sample              i_sample,
    input  wire vet_pkg::t_sample              i_last_rst,
    input  wire logic [vet_pkg::COEF_W-1:0]    i_coeff,
    output vet_pkg::t_lane_out                 o_out
);
    import vet_pkg::*;

    localparam int SHF_W = PROD_W - COEF_W;

    logic signed [HP_W-1:0]   r_hp;
    t_sample                  r_last;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]          r_sq;
    logic [3:0]               r_stage;

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SUM_W-1:0]     n_sum;
    logic signed [PROD_W-1:0]    n_prod;
    logic signed [SHF_W-1:0]     shf;
    logic                        fits;
    logic signed [HP_W-1:0]      n_hp;
    logic [HP_W-1:0]             hp_abs;
    logic [SQ_W-1:0]             n_sq;

    assign diff   = {i_sample[SAMPLE_BITS-1], i_sample} - {r_last[SAMPLE_BITS-1], r_last};
    assign n_sum  = SUM_W'(r_hp) + (SUM_W'(diff) <<< FRAC_W);
    assign n_prod = r_sum * $signed({1'b0, i_coeff});

    // floor(prod / 2^16), then clamp to the 32-bit range
    assign shf  = r_prod[PROD_W-1:COEF_W];
    assign fits = (&shf[SHF_W-1:HP_W-1]) | ~(|shf[SHF_W-1:HP_W-1]);

    always_comb begin
        if (fits) begin
            n_hp = shf[HP_W-1:0];
        end else if (shf[SHF_W-1]) begin
            n_hp = {1'b1, {(HP_W-1){1'b0}}};
        end else begin
            n_hp = {1'b0, {(HP_W-1){1'b1}}};
        end
    end

    assign hp_abs = r_hp[HP_W-1] ? (~r_hp + 1'b1) : r_hp;
    assign n_sq   = hp_abs * hp_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_hp    <= '0;
            r_last  <= i_last_rst;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
            if (i_start) begin
                r_sum  <= n_sum;
                r_last <= i_sample;
            end
            if (r_stage[0]) begin
                r_prod <= n_prod;
            end
            if (r_stage[1]) begin
                r_hp <= n_hp;
            end
            if (r_stage[2]) begin
                r_sq <= n_sq;
            end
        end
    end

    assign o_out.valid = r_stage[3];
    assign o_out.sq    = r_sq;

endmodule

`default_nettype wire

FILE: rtl/core/vet_isqrt.sv
// Floor integer square root, one result bit per cycle (digit by digit).
// Depends on vet_pkg.
`default_nettype none

module vet_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [vet_pkg::SQ_W-1:0]    i_radicand,
    output logic                             o_done,
    output logic [vet_pkg::ROOT_W-1:0]       o_root
);
    import vet_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic                r_run;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SQ_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                take;

    // bring down the next two radicand bits, try (root << 2) | 1
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_run) begin
                r_rad  <= r_rad << 2;
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: rtl/core/vet_env.sv
// Envelope follower: env += floor(k * (mag - env) / 2^16), saturated, plus the
// clamped integer output level. Depends on vet_pkg.
`default_nettype none

module vet_env (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [vet_pkg::ROOT_W-1:0]  i_mag,
    input  wire logic [vet_pkg::COEF_W-1:0]  i_gain,
    output logic                             o_done,
    output logic [vet_pkg::LEVEL_W-1:0]      o_level
);
    import vet_pkg::*;

    localparam int STEP_W = EPROD_W - COEF_W;

    logic signed [HP_W-1:0]    r_env;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [EPROD_W-1:0] r_prod;
    logic [2:0]                r_stage;

    logic signed [DELTA_W-1:0] n_delta;
    logic signed [EPROD_W-1:0] n_prod;
    logic signed [STEP_W-1:0]  step;
    logic signed [ESUM_W-1:0]  total;
    logic                      fits;
    logic signed [HP_W-1:0]    n_env;

    assign n_delta = $signed({2'b00, i_mag}) - DELTA_W'(r_env);
    assign n_prod  = r_delta * $signed({1'b0, i_gain});
    assign step    = r_prod[EPROD_W-1:COEF_W];
    assign total   = ESUM_W'(r_env) + ESUM_W'(step);
    assign fits    = (&total[ESUM_W-1:HP_W-1]) | ~(|total[ESUM_W-1:HP_W-1]);

    always_comb begin
        if (fits) begin
            n_env = total[HP_W-1:0];
        end else if (total[ESUM_W-1]) begin
            n_env = {1'b1, {(HP_W-1){1'b0}}};
        end else begin
            n_env = {1'b0, {(HP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_env   <= '0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            if (i_start) begin
                r_delta <= n_delta;
            end
            if (r_stage[0]) begin
                r_prod <= n_prod;
            end
            if (r_stage[1]) begin
                r_env <= n_env;
            end
        end
    end

    assign o_done  = r_stage[2];
    // zero for a negative or zero envelope
    assign o_level = (!r_env[HP_W-1] && (|r_env)) ? r_env[FRAC_W +: LEVEL_W] : '0;

endmodule

`default_nettype wire

FILE: dv/vibration_envelope_tracker_tb.sv
// Self-checking testbench for vibration_envelope_tracker: directed table, then random
// three-axis samples under sender/receiver idling, checked against a built-in predictor.
// Depends on vet_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module vibration_envelope_tracker_tb;
    import vet_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     DRAIN_CYCLES = 60;      // extra wait once no level is outstanding
    localparam int     CHUNKS       = 6;
    localparam int     CHUNK_WORDS  = 100;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    // index 3 is not a register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        t_sample                x;
        t_sample                y;
        t_sample                z;
        logic                   has_level;
        logic [LEVEL_W-1:0]     level;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]     s_tdata = '0;
    logic                      m_tready = 1'b0;
    wire                       o_cfg_ready;
    wire                       o_s_axis_tready;
    wire                       o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]     o_m_axis_tdata;

    vibration_envelope_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // predictor state
    longint             hp_coef;
    longint             env_gain;
    logic               trk_en;
    int                 hp_st [3];
    int                 last_st [3];
    int                 env_st;
    logic [LEVEL_W-1:0] level_q [$];

    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    bit  need_drain = 1'b0;
    int  n_fail = 0;
    int  n_words = 0;
    int  n_dropped = 0;
    int  n_levels = 0;
    int  n_writes = 0;
    int  cycles = 0;

    function automatic int clamp32(input longint v);
        if (v > S32_MAX) return int'(S32_MAX);
        if (v < S32_MIN) return int'(S32_MIN);
        return int'(v);
    endfunction

    // one-pole high-pass step in Q23.8; >>> on a signed longint floors
    function automatic int hp_next(input int hp, input int cur, input int prev);
        longint acc;
        acc = longint'(hp) + (longint'(cur) - longint'(prev)) * 64'sd256;
        return clamp32((acc * hp_coef) >>> 16);
    endfunction

    function automatic logic [63:0] square_mag(input int v);
        logic [63:0] m;
        m = (v < 0) ? -longint'(v) : longint'(v);
        return m * m;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    task automatic reset_model();
        hp_coef  = longint'(62259);
        env_gain = longint'(13107);
        trk_en   = 1'b1;
        hp_st    = '{0, 0, 0};
        last_st  = '{-19, -51, 1032};
        env_st   = 0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_HP_COEFF: hp_coef = longint'(val);
            CFG_ENV_GAIN: env_gain = longint'(val);
            CFG_ENABLE:   trk_en = val[0];
            default:      ;
        endcase
    endtask

    // update predictor on an accepted sample word; queue its expected level if enabled
    task automatic track_sample(input t_sample sx, input t_sample sy, input t_sample sz,
                                input logic has_level, input logic [LEVEL_W-1:0] level);
        int          cur [3];
        logic [63:0] sumsq;
        logic [63:0] mag;
        longint      delta;
        cur[0] = sx;
        cur[1] = sy;
        cur[2] = sz;
        n_words++;
        if (!trk_en) begin
            n_dropped++;
            return;
        end
        sumsq = '0;
        for (int a = 0; a < 3; a++) begin
            hp_st[a] = hp_next(hp_st[a], cur[a], last_st[a]);
            last_st[a] = cur[a];
            sumsq += square_mag(hp_st[a]);
        end
        mag = root_floor(sumsq);
        delta = longint'(mag) - longint'(env_st);
        env_st = clamp32(longint'(env_st) + ((delta * env_gain) >>> 16));
        if (has_level)
            level_q.push_back(level);
        else
            level_q.push_back(env_st > 0 ? env_st[31:8] : '0);
    endtask

    // entered and left at a falling edge; valid stays high for a following word
    task automatic send_sample(input t_sample sx, input t_sample sy, input t_sample sz,
                               input logic has_level, input logic [LEVEL_W-1:0] level);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({sz, sy, sx});
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_sample(sx, sy, sz, has_level, level);
        need_drain = 1'b1;
        @(negedge i_clk);
    endtask

    // register writes only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        if (need_drain) begin
            while (level_q.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            @(negedge i_clk);
            need_drain = 1'b0;
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_write(idx, val);
        n_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_row smp_row(input int x, input int y, input int z,
                                     input logic has_level, input int level);
        t_row r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.x = t_sample'(x);
        r.y = t_sample'(y);
        r.z = t_sample'(z);
        r.has_level = has_level;
        r.level = LEVEL_W'(level);
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.val = CFG_DATA_W'(val);
        return r;
    endfunction

    function automatic t_sample pick_extreme();
        case ($urandom_range(0, 3))
            0:       return t_sample'(-2048);
            1:       return t_sample'(2047);
            2:       return t_sample'(0);
            default: return t_sample'(-1);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(60000, 65535));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // level stream sink
    always @(negedge i_clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && m_tready) begin
            if (level_q.size() == 0) begin
                $error("vibration_level: unexpected word, actual %0d",
                       o_m_axis_tdata[LEVEL_W-1:0]);
                n_fail++;
            end else begin
                if (o_m_axis_tdata[LEVEL_W-1:0] !== level_q[0]) begin
                    $error("vibration_level: expected %0d, actual %0d",
                           level_q[0], o_m_axis_tdata[LEVEL_W-1:0]);
                    n_fail++;
                end
                void'(level_q.pop_front());
                n_levels++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels outstanding", cycles, level_q.size());
            $display("vibration_envelope_tracker: mismatch");
            $finish;
        end
    end

    initial begin
        t_row    dir_rows [$];
        t_sample bx, by, bz;
        t_sample sx, sy, sz;
        int      mode;
        int      len;

        reset_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir_rows = '{
            // first word equals the reset history: nothing moves, level 0
            smp_row(-19, -51, 1032, 1'b1, 0),
            smp_row(2047, -2048, 0, 1'b0, 0),
            smp_row(-2048, 2047, -1, 1'b0, 0),
            smp_row(-1, -1, -1, 1'b0, 0),
            smp_row(0, 0, 0, 1'b0, 0),
            smp_row(1, -2, 1365, 1'b0, 0),
            reg_row(CFG_HP_COEFF, 65535),
            reg_row(CFG_ENV_GAIN, 65535),
            smp_row(2047, 2047, 2047, 1'b0, 0),
            smp_row(-2048, -2048, -2048, 1'b0, 0),
            smp_row(2047, -2048, 2047, 1'b0, 0),
            smp_row(-2048, 2047, -2048, 1'b0, 0),
            // zero gain: envelope holds
            reg_row(CFG_ENV_GAIN, 0),
            smp_row(0, 0, 0, 1'b0, 0),
            smp_row(2047, 0, -2048, 1'b0, 0),
            // zero pole kills the filters; full gain collapses the envelope in two words
            reg_row(CFG_HP_COEFF, 0),
            reg_row(CFG_ENV_GAIN, 65535),
            smp_row(2047, -2048, 2047, 1'b0, 0),
            smp_row(-2048, 2047, 0, 1'b1, 0),
            reg_row(CFG_UNUSED, 65535),
            smp_row(5, -5, 100, 1'b1, 0),
            // enable takes bit 0 only
            reg_row(CFG_ENABLE, 16'hFFFE),
            smp_row(2047, 2047, 2047, 1'b0, 0),
            smp_row(-2048, -2048, -2048, 1'b0, 0),
            reg_row(CFG_ENABLE, 16'h0001),
            reg_row(CFG_HP_COEFF, 62259),
            reg_row(CFG_ENV_GAIN, 13107),
            smp_row(100, -100, 1000, 1'b0, 0),
            smp_row(-2048, 2047, -2048, 1'b0, 0),
            smp_row(0, 0, 0, 1'b0, 0),
            smp_row(12, 34, -56, 1'b0, 0)
        };

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_sample(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                            dir_rows[r].has_level, dir_rows[r].level);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
            sink_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
            for (int c = 0; c < CHUNKS; c++) begin
                if (c == 0) begin
                    write_reg(CFG_HP_COEFF, '1);
                    write_reg(CFG_ENV_GAIN, '1);
                end else if (c == 1) begin
                    write_reg(CFG_HP_COEFF, '0);
                    write_reg(CFG_ENV_GAIN, '0);
                end else begin
                    write_reg(CFG_HP_COEFF, pick_coef());
                    write_reg(CFG_ENV_GAIN, pick_coef());
                end
                // an occasional short disabled run; dropped words produce no level
                if (c > 1 && $urandom_range(0, 3) == 0) begin
                    write_reg(CFG_ENABLE, CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1));
                    repeat ($urandom_range(2, 8))
                        send_sample(t_sample'($urandom), t_sample'($urandom),
                                    t_sample'($urandom), 1'b0, '0);
                end
                write_reg(CFG_ENABLE, CFG_DATA_W'($urandom) | CFG_DATA_W'(1));
                bx = t_sample'($urandom);
                by = t_sample'($urandom);
                bz = t_sample'($urandom);
                len = CHUNK_WORDS;
                for (int i = 0; i < len; i++) begin
                    mode = $urandom_range(0, 9);
                    if (mode < 4) begin
                        sx = t_sample'($urandom);
                        sy = t_sample'($urandom);
                        sz = t_sample'($urandom);
                    end else if (mode < 8) begin
                        // small vibration around a resting offset
                        sx = t_sample'(int'(bx) + int'($urandom_range(0, 64)) - 32);
                        sy = t_sample'(int'(by) + int'($urandom_range(0, 64)) - 32);
                        sz = t_sample'(int'(bz) + int'($urandom_range(0, 64)) - 32);
                    end else begin
                        sx = pick_extreme();
                        sy = pick_extreme();
                        sz = pick_extreme();
                    end
                    send_sample(sx, sy, sz, 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d sample words sent (%0d dropped while disabled), %0d levels checked,",
                 n_words, n_dropped, n_levels);
        $display("%0d register writes across pole/gain extremes, three idling regimes",
                 n_writes);
        if (n_fail == 0)
            $display("vibration_envelope_tracker: match");
        else
            $display("vibration_envelope_tracker: mismatch");
        $finish;
    end

endmodule
